// ----- src/cqs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_pkg: shared types and codes for the circular queue with search
// Request and response payloads, operation and status codes, and the
// control/status bundles between the top level and the queue core.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_FIND = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int WORD_W = 32;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_out;
    logic [2:0]               slot_index;
    logic [3:0]               fill_level;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic take;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_sts_t;

endpackage

// ----- src/cqs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/cqs_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_core: queue pointers, slot storage and search sequencer
// Runs one operation at a time; a find walks the slots from head through
// the single RAM read port and one 32-bit comparator, one slot per cycle.
// ----------------------------------------------------------------------------
module cqs_core #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  cqs_pkg::seq_ctl_t ctl,
  input  cqs_pkg::req_t     req,
  output cqs_pkg::seq_sts_t sts,
  output cqs_pkg::rsp_t     rsp
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [CW-1:0] occ, occ_next;
  logic [PW-1:0] scan, scan_next;
  logic [PW-1:0] cnt, cnt_next;
  logic [cqs_pkg::WORD_W-1:0] value_r, value_next;
  logic [1:0]    status_r, status_next;
  logic [cqs_pkg::WORD_W-1:0] data_r, data_next;
  logic [PW-1:0] slot_r, slot_next;

  logic                        we;
  logic [PW-1:0]               raddr;
  logic [cqs_pkg::WORD_W-1:0]  rdata;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  cqs_ram #(
    .WIDTH(cqs_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(tail),
    .wdata(req.value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    occ_next    = occ;
    scan_next   = scan;
    cnt_next    = cnt;
    value_next  = value_r;
    status_next = status_r;
    data_next   = data_r;
    slot_next   = slot_r;
    we          = 1'b0;
    raddr       = head;
    case (state)
      S_IDLE: begin
        if (ctl.start) begin
          value_next  = req.value;
          status_next = cqs_pkg::ST_OK;
          data_next   = '0;
          slot_next   = '0;
          scan_next   = head;
          cnt_next    = '0;
          state_next  = S_DONE;
          case (req.mode)
            cqs_pkg::MODE_ENQ: begin
              if (occ == CW'(DEPTH)) begin
                status_next = cqs_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                tail_next = nxt(tail);
                occ_next  = occ + 1'b1;
              end
            end
            cqs_pkg::MODE_DEQ: begin
              if (occ == '0) begin
                status_next = cqs_pkg::ST_EMPTY;
              end else begin
                state_next = S_DEQ;
              end
            end
            cqs_pkg::MODE_FIND: begin
              if (occ == '0) begin
                status_next = cqs_pkg::ST_EMPTY;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              status_next = cqs_pkg::ST_OK;
            end
          endcase
        end
      end
      S_DEQ: begin
        data_next = rdata;
        occ_next  = occ - 1'b1;
        // queue drains: both pointers go back to slot zero
        if (occ == CW'(1)) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          head_next = nxt(head);
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        // prefetch the following slot while comparing the current one
        raddr = nxt(scan);
        if (rdata == value_r) begin
          slot_next  = scan;
          state_next = S_DONE;
        end else if (CW'(cnt) + CW'(1) == occ) begin
          status_next = cqs_pkg::ST_NOTFOUND;
          state_next  = S_DONE;
        end else begin
          scan_next = nxt(scan);
          cnt_next  = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (ctl.take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    scan     <= scan_next;
    cnt      <= cnt_next;
    value_r  <= value_next;
    status_r <= status_next;
    data_r   <= data_next;
    slot_r   <= slot_next;
  end

  assign sts.idle = (state == S_IDLE);
  assign sts.done = (state == S_DONE);

  assign rsp.status     = status_r;
  assign rsp.data_out   = signed'(data_r);
  assign rsp.slot_index = 3'(slot_r);
  assign rsp.fill_level = 4'(occ);

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> (head == '0 && tail == '0))
    else $error("empty queue with pointers off slot zero");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> (state == S_IDLE))
    else $error("operation started while busy");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(cnt) < occ))
    else $error("search ran past the newest entry");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (occ != '0 && occ != CW'(DEPTH)) |-> (head != tail))
    else $error("pointers meet on a partly filled queue");
`endif

endmodule

// ----- src/circular_queue_with_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_search_top: circular queue with linear search
// Enqueue, dequeue and find on a DEPTH-entry queue of 32-bit words, with a
// response register between the queue core and the response channel.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+--------------------------------------
//   request | req_valid | req_ready | req: mode, value
//   response| rsp_valid | rsp_ready | rsp: status, data_out, slot_index,
//           |           |           |      fill_level
//
// Enqueue and mode three go straight to the done state, dequeue passes through
// a read state, and find scans: the core reads one slot a cycle through the
// single RAM read port and compares it against the target.
// Reset clears the state, pointers, count and response valid only; slot contents need no clearing.
// A result waiting on rsp_ready does not block the next request; a second
// finished result holds in the core until the response register frees.
// ----------------------------------------------------------------------------
module circular_queue_with_search_top #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cqs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cqs_pkg::rsp_t rsp
);

  cqs_pkg::seq_ctl_t ctl;
  cqs_pkg::seq_sts_t sts;
  cqs_pkg::rsp_t     core_rsp;

  assign req_ready = sts.idle;
  assign ctl.start = req_valid && sts.idle;
  // move the finished result over when the response register is free
  assign ctl.take  = sts.done && (!rsp_valid || rsp_ready);

  cqs_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .req(req),
    .sts(sts),
    .rsp(core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rsp <= core_rsp;
    end
  end

endmodule

// ----- tb/sv/cqs_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_queue_checker: response checker for the circular queue with search
// Watches both channels, keeps its own copy of the queue to work out the
// response to every request transfer, and compares each response transfer
// against the oldest response still due, field by field.
// ----------------------------------------------------------------------------
module cqs_queue_checker #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  cqs_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  cqs_pkg::rsp_t rsp,
  output int            errors,
  output int            pending
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [cqs_pkg::WORD_W-1:0] words [DEPTH];
  logic [PTR_W-1:0]           oldest;
  logic [PTR_W-1:0]           next_wr;
  int                         count;
  cqs_pkg::rsp_t              due_q [$];
  cqs_pkg::rsp_t              want;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one request to the shadow queue and return the response it earns.
  function automatic cqs_pkg::rsp_t queue_step(input cqs_pkg::req_t r);
    cqs_pkg::rsp_t    res;
    logic [PTR_W-1:0] p;
    bit               hit;
    res = '0;
    case (r.mode)
      cqs_pkg::MODE_ENQ: begin
        if (count >= DEPTH) begin
          res.status = cqs_pkg::ST_FULL;
        end else begin
          words[next_wr] = r.value;
          next_wr = wrap_inc(next_wr);
          count++;
        end
      end
      cqs_pkg::MODE_DEQ: begin
        if (count == 0) begin
          res.status = cqs_pkg::ST_EMPTY;
        end else begin
          res.data_out = words[oldest];
          count--;
          // an emptied queue starts over at slot zero
          if (count == 0) begin
            oldest = '0;
            next_wr = '0;
          end else begin
            oldest = wrap_inc(oldest);
          end
        end
      end
      cqs_pkg::MODE_FIND: begin
        if (count == 0) begin
          res.status = cqs_pkg::ST_EMPTY;
        end else begin
          p = oldest;
          hit = 0;
          for (int n = 0; n < count && !hit; n++) begin
            if (words[p] == r.value) begin
              hit = 1;
              res.slot_index = 3'(p);
            end else begin
              p = wrap_inc(p);
            end
          end
          if (!hit) res.status = cqs_pkg::ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    res.fill_level = 4'(count);
    return res;
  endfunction

  task automatic flag(input string field, input logic [cqs_pkg::WORD_W-1:0] want_v,
                      input logic [cqs_pkg::WORD_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      oldest = '0;
      next_wr = '0;
      count = 0;
      due_q.delete();
      pending = 0;
    end else begin
      // check the response before logging a new request on the same edge
      if (rsp_valid && rsp_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: response transfer with nothing due, got %p", $time, rsp);
          errors++;
        end else begin
          want = due_q.pop_front();
          flag("status", 32'(want.status), 32'(rsp.status));
          flag("data_out", want.data_out, rsp.data_out);
          flag("slot_index", 32'(want.slot_index), 32'(rsp.slot_index));
          flag("fill_level", 32'(want.fill_level), 32'(rsp.fill_level));
        end
      end
      if (req_valid && req_ready) due_q.push_back(queue_step(req));
      pending = due_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_circular_queue_with_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_queue_with_search_top: testbench for the circular queue
// Drives directed corner cases (empty, full, duplicates, wrap, unused mode)
// then phased random traffic that swings the queue between full and empty,
// with random idling on both sides and one long response stall.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_search_top;

  localparam int          DEPTH       = 8;
  localparam int          RAND_ITEMS  = 1400;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_AT     = 300;
  localparam int          HOLD_CYCLES = 150;
  localparam int          CALM_FROM   = 700;
  localparam int          CALM_TO     = 900;
  localparam logic [1:0]  MODE_NONE   = 2'd3;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  cqs_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  cqs_pkg::rsp_t rsp;

  int   errors;
  int   pending;
  int   sent;
  int   cycles;
  logic req_fire;
  logic signed [cqs_pkg::WORD_W-1:0] pool [16];

  circular_queue_with_search_top #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  cqs_queue_checker #(.DEPTH(DEPTH)) u_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    req_fire <= req_valid && req_ready;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_circular_queue_with_search_top failed");
      $finish;
    end
  end

  function automatic bit in_calm();
    return sent >= CALM_FROM && sent < CALM_TO;
  endfunction

  // Receiver: random stalls, one long hold-off, and a stall-free window.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent >= HOLD_AT) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (in_calm()) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 31);
      end
    end
  end

  // Offer one request; entered and left at a falling edge after its transfer.
  task automatic offer(input logic [1:0] m, input logic signed [cqs_pkg::WORD_W-1:0] v);
    while (!in_calm() && $urandom_range(99) < 31) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{mode: m, value: v};
    sent++;
    do @(negedge clk); while (!req_fire);
  endtask

  function automatic logic signed [cqs_pkg::WORD_W-1:0] pick_word();
    if ($urandom_range(99) < 75) return pool[$urandom_range(15)];
    return $urandom;
  endfunction

  initial begin
    int          enq_bias;
    int          phase_left;
    int          r;
    logic [1:0]  m;
    cycles = 0;
    sent = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    pool[0] = 32'sh7FFF_FFFF;
    pool[1] = 32'sh8000_0000;
    pool[2] = '0;
    pool[3] = -32'sd1;
    for (int i = 4; i < 16; i++) pool[i] = $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // operations on an empty queue
    offer(cqs_pkg::MODE_DEQ, 32'sd0);
    offer(cqs_pkg::MODE_FIND, 32'sd0);
    offer(MODE_NONE, -32'sd1);
    // fill to the brim, with a duplicate to check the first match wins
    offer(cqs_pkg::MODE_ENQ, 32'sh7FFF_FFFF);
    offer(cqs_pkg::MODE_ENQ, 32'sh8000_0000);
    offer(cqs_pkg::MODE_ENQ, 32'sd0);
    offer(cqs_pkg::MODE_ENQ, -32'sd1);
    offer(cqs_pkg::MODE_ENQ, 32'sd5);
    offer(cqs_pkg::MODE_ENQ, 32'sd5);
    offer(cqs_pkg::MODE_ENQ, 32'sh5A5A_A5A5);
    offer(cqs_pkg::MODE_ENQ, 32'sh1234_5678);
    offer(cqs_pkg::MODE_ENQ, 32'sd99);
    offer(cqs_pkg::MODE_FIND, 32'sd5);
    offer(cqs_pkg::MODE_FIND, -32'sd1);
    offer(cqs_pkg::MODE_FIND, 32'sd123);
    offer(MODE_NONE, 32'sd0);
    offer(cqs_pkg::MODE_DEQ, 32'sd0);
    offer(cqs_pkg::MODE_DEQ, 32'sd0);
    offer(cqs_pkg::MODE_DEQ, 32'sd0);
    // enqueue behind the wrapped tail and search across the wrap
    offer(cqs_pkg::MODE_ENQ, 32'sd77);
    offer(cqs_pkg::MODE_ENQ, 32'sd5);
    offer(cqs_pkg::MODE_FIND, 32'sd77);
    offer(cqs_pkg::MODE_FIND, 32'sd5);

    // phases lean toward enqueue or dequeue so the queue keeps
    // swinging between full and empty
    phase_left = 0;
    enq_bias = 50;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 12);
        case ($urandom_range(2))
          0: enq_bias = 15;
          1: enq_bias = 50;
          default: enq_bias = 85;
        endcase
      end
      phase_left--;
      r = $urandom_range(99);
      if (r < 4) m = MODE_NONE;
      else if (r < 30) m = cqs_pkg::MODE_FIND;
      else if ($urandom_range(99) < enq_bias) m = cqs_pkg::MODE_ENQ;
      else m = cqs_pkg::MODE_DEQ;
      offer(m, pick_word());
    end
    req_valid <= 1'b0;

    wait (pending == 0);
    repeat (DEPTH + 4) @(negedge clk);
    if (errors == 0) begin
      $display("tb_circular_queue_with_search_top passed");
    end else begin
      $display("tb_circular_queue_with_search_top failed");
    end
    $finish;
  end

endmodule
